[sv/tcw_pkg.sv]
package tcw_pkg;

   localparam int NEXT_CELL_W = 11;
   localparam int CMD_COL_W   = 8;
   localparam int CMD_ROW_W   = 7;
   localparam int CMD_CELL_W  = 15;
   localparam int CSR_INDEX_W = 1;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_ERROR     = 8'h45;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_ATTR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_ATTR   = 1'b1;

   localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
   localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_BLANK,
      OP_NEWLINE,
      OP_ERR_MARK,
      OP_CLEAR,
      OP_READ,
      OP_READ_ERR,
      OP_NOP
   } tcw_op_type;

   typedef struct packed {
      tcw_op_type             op;
      logic                   at_cursor;
      logic [7:0]             char_code;
      logic [7:0]             attr;
      logic [CMD_COL_W-1:0]   col;
      logic [CMD_ROW_W-1:0]   row;
      logic [CMD_CELL_W-1:0]  cell_idx;
   } tcw_cmd_type;

endpackage

[sv/tcw_req_if.sv]
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] char_code;
   logic [7:0] attr;
   logic       at_cursor;
   logic [7:0] col;
   logic [7:0] row;

   modport source (
      output valid, req_type, char_code, attr, at_cursor, col, row,
      input  ready
   );

   modport sink (
      input  valid, req_type, char_code, attr, at_cursor, col, row,
      output ready
   );
endinterface

[sv/tcw_rsp_if.sv]
interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::NEXT_CELL_W-1:0] next_cell;
   logic                          coord_error;
   logic [7:0]                    read_char;
   logic [7:0]                    read_attr;

   modport source (
      output valid, next_cell, coord_error, read_char, read_attr,
      input  ready
   );

   modport sink (
      input  valid, next_cell, coord_error, read_char, read_attr,
      output ready
   );
endinterface

[sv/tcw_front.sv]
module tcw_front #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   tcw_req_if.sink              req_chan,
   input  logic                 enable,
   input  logic [7:0]           default_attr,
   input  logic                 q_room,
   output logic                 q_push,
   output tcw_pkg::tcw_cmd_type q_cmd
);
   import tcw_pkg::*;

   logic       col_bad;
   logic       row_bad;
   logic       bad;
   logic [7:0] attr_eff;

   assign req_chan.ready = enable && q_room;
   assign q_push         = req_chan.valid && req_chan.ready;

   assign col_bad  = {1'b0, req_chan.col} >= 9'(SCREEN_COLS);
   assign row_bad  = req_chan.row >= 8'(SCREEN_ROWS);
   assign bad      = !req_chan.at_cursor && (col_bad || row_bad);
   assign attr_eff = (req_chan.attr == 8'd0) ? default_attr : req_chan.attr;

   always_comb begin
      q_cmd.at_cursor = req_chan.at_cursor;
      q_cmd.char_code = req_chan.char_code;
      q_cmd.attr      = attr_eff;
      q_cmd.col       = req_chan.col[CMD_COL_W-1:0];
      q_cmd.row       = req_chan.row[CMD_ROW_W-1:0];
      q_cmd.cell_idx  = CMD_CELL_W'(req_chan.row[CMD_ROW_W-1:0]) * CMD_CELL_W'(SCREEN_COLS)
                      + CMD_CELL_W'(req_chan.col);
      q_cmd.op        = OP_NOP;
      unique case (req_chan.req_type)
         REQ_WRITE: begin
            priority if (bad) begin
               q_cmd.op = OP_ERR_MARK;
            end else if (req_chan.char_code == CH_NEWLINE) begin
               q_cmd.op = OP_NEWLINE;
            end else if (req_chan.char_code == CH_BACKSPACE) begin
               q_cmd.op        = OP_BLANK;
               q_cmd.char_code = CH_SPACE;
            end else begin
               q_cmd.op = OP_PUT;
            end
         end
         REQ_CLEAR: q_cmd.op = OP_CLEAR;
         REQ_READ:  q_cmd.op = bad ? OP_READ_ERR : OP_READ;
         default:   q_cmd.op = OP_NOP;
      endcase
   end
endmodule

[sv/tcw_queue.sv]
module tcw_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tcw_pkg::tcw_cmd_type push_cmd,
   output logic                 room,
   input  logic                 pop,
   output logic                 head_valid,
   output tcw_pkg::tcw_cmd_type head_cmd
);
   import tcw_pkg::*;

   tcw_cmd_type entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;

   assign room       = count_ff != 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[sv/tcw_back.sv]
module tcw_back #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  tcw_pkg::tcw_cmd_type q_cmd,
   output logic                 q_pop,
   input  logic [7:0]           default_attr,
   input  logic [7:0]           error_attr,
   output logic                 init_done,
   tcw_rsp_if.source            rsp_chan
);
   import tcw_pkg::*;

   localparam int CELLS          = SCREEN_COLS * SCREEN_ROWS;
   localparam int COL_W          = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
   localparam int ROW_W          = $clog2(SCREEN_ROWS);
   localparam int CELL_W         = $clog2(CELLS);
   localparam int LAST_CELL      = CELLS - 1;
   localparam int LAST_ROW_START = CELLS - SCREEN_COLS;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_DRAIN,
      ST_ZERO,
      ST_CLEAR
   } state_type;

   state_type           state_ff;
   logic [CELL_W-1:0]   cnt_ff;
   logic [CELL_W-1:0]   copy_wa_ff;
   logic                pend_ff;
   logic [7:0]          fill_attr_ff;
   logic [COL_W-1:0]    cur_col_ff;
   logic [ROW_W-1:0]    cur_row_ff;
   logic [CELL_W-1:0]   cur_cell_ff;

   logic                rsp_valid_ff;
   logic [NEXT_CELL_W-1:0] rsp_next_cell_ff;
   logic                rsp_err_ff;
   logic [7:0]          rsp_char_ff;
   logic [7:0]          rsp_attr_ff;

   logic [15:0]         mem [CELLS];
   logic [15:0]         rd_data_ff;
   logic                mem_we;
   logic [CELL_W-1:0]   mem_waddr;
   logic [15:0]         mem_wdata;
   logic                mem_re;
   logic [CELL_W-1:0]   mem_raddr;

   logic                slot_free;
   logic [COL_W-1:0]    tgt_col;
   logic [ROW_W-1:0]    tgt_row;
   logic [CELL_W-1:0]   tgt_cell;
   logic                col_last;
   logic                row_last;
   logic [CELL_W-1:0]   next_row_start;
   logic [COL_W-1:0]    new_col_in;
   logic [ROW_W-1:0]    new_row_in;
   logic [CELL_W-1:0]   new_cell_in;
   logic                scroll_in;

   assign init_done = state_ff != ST_INIT;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid && slot_free;

   assign tgt_col  = q_cmd.at_cursor ? cur_col_ff  : q_cmd.col[COL_W-1:0];
   assign tgt_row  = q_cmd.at_cursor ? cur_row_ff  : q_cmd.row[ROW_W-1:0];
   assign tgt_cell = q_cmd.at_cursor ? cur_cell_ff : q_cmd.cell_idx[CELL_W-1:0];
   assign col_last = tgt_col == COL_W'(SCREEN_COLS - 1);
   assign row_last = tgt_row == ROW_W'(SCREEN_ROWS - 1);
   assign next_row_start = tgt_cell - CELL_W'(tgt_col) + CELL_W'(SCREEN_COLS);

   // cursor after a write
   always_comb begin
      new_col_in  = tgt_col;
      new_row_in  = tgt_row;
      new_cell_in = tgt_cell;
      scroll_in   = 1'b0;
      unique case (q_cmd.op)
         OP_PUT: begin
            if (col_last) begin
               new_col_in = '0;
               if (row_last) begin
                  scroll_in   = 1'b1;
                  new_cell_in = CELL_W'(LAST_ROW_START);
               end else begin
                  new_row_in  = tgt_row + 1'b1;
                  new_cell_in = tgt_cell + 1'b1;
               end
            end else begin
               new_col_in  = tgt_col + 1'b1;
               new_cell_in = tgt_cell + 1'b1;
            end
         end
         OP_NEWLINE: begin
            new_col_in = '0;
            if (row_last) begin
               scroll_in   = 1'b1;
               new_cell_in = CELL_W'(LAST_ROW_START);
            end else begin
               new_row_in  = tgt_row + 1'b1;
               new_cell_in = next_row_start;
            end
         end
         OP_BLANK, OP_ERR_MARK, OP_CLEAR, OP_READ, OP_READ_ERR, OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = 16'd0;
      mem_re    = 1'b0;
      mem_raddr = cnt_ff;
      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            if (q_pop) begin
               unique case (q_cmd.op)
                  OP_PUT, OP_BLANK: begin
                     mem_we    = 1'b1;
                     mem_waddr = tgt_cell;
                     mem_wdata = {q_cmd.attr, q_cmd.char_code};
                  end
                  OP_ERR_MARK: begin
                     mem_we    = 1'b1;
                     mem_waddr = CELL_W'(LAST_CELL);
                     mem_wdata = {error_attr, CH_ERROR};
                  end
                  OP_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = tgt_cell;
                  end
                  OP_NEWLINE, OP_CLEAR, OP_READ_ERR, OP_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            mem_re    = 1'b1;
            mem_we    = pend_ff;
            mem_waddr = copy_wa_ff;
            mem_wdata = rd_data_ff;
         end
         ST_DRAIN: begin
            mem_we    = 1'b1;
            mem_waddr = copy_wa_ff;
            mem_wdata = rd_data_ff;
         end
         ST_ZERO: begin
            mem_we = 1'b1;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = {fill_attr_ff, CH_SPACE};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cur_cell_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CELL_W'(LAST_CELL)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (q_pop) begin
                  rsp_valid_ff     <= q_cmd.op != OP_READ;
                  rsp_next_cell_ff <= NEXT_CELL_W'(cur_cell_ff);
                  rsp_err_ff       <= 1'b0;
                  rsp_char_ff      <= 8'd0;
                  rsp_attr_ff      <= 8'd0;
                  unique case (q_cmd.op)
                     OP_PUT, OP_BLANK, OP_NEWLINE: begin
                        cur_col_ff       <= new_col_in;
                        cur_row_ff       <= new_row_in;
                        cur_cell_ff      <= new_cell_in;
                        rsp_next_cell_ff <= NEXT_CELL_W'(new_cell_in);
                        if (scroll_in) begin
                           state_ff <= ST_COPY;
                           cnt_ff   <= CELL_W'(SCREEN_COLS);
                           pend_ff  <= 1'b0;
                        end
                     end
                     OP_ERR_MARK, OP_READ_ERR: begin
                        rsp_err_ff <= 1'b1;
                     end
                     OP_CLEAR: begin
                        cur_col_ff       <= '0;
                        cur_row_ff       <= '0;
                        cur_cell_ff      <= '0;
                        rsp_next_cell_ff <= '0;
                        fill_attr_ff     <= default_attr;
                        state_ff         <= ST_CLEAR;
                        cnt_ff           <= '0;
                     end
                     OP_READ: begin
                        state_ff <= ST_READ;
                     end
                     OP_NOP: begin
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_char_ff  <= rd_data_ff[7:0];
               rsp_attr_ff  <= rd_data_ff[15:8];
               state_ff     <= ST_IDLE;
            end
            ST_COPY: begin
               copy_wa_ff <= cnt_ff - CELL_W'(SCREEN_COLS);
               pend_ff    <= 1'b1;
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == CELL_W'(LAST_CELL)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               pend_ff  <= 1'b0;
               cnt_ff   <= CELL_W'(LAST_ROW_START);
               state_ff <= ST_ZERO;
            end
            ST_ZERO, ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CELL_W'(LAST_CELL)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.next_cell   = rsp_next_cell_ff;
   assign rsp_chan.coord_error = rsp_err_ff;
   assign rsp_chan.read_char   = rsp_char_ff;
   assign rsp_chan.read_attr   = rsp_attr_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(cur_cell_ff) < CELLS)
      else $error("cursor past end of store");

   a_cursor_consistent: assert property (@(posedge clock) disable iff (reset)
      int'(cur_cell_ff) == int'(cur_row_ff) * SCREEN_COLS + int'(cur_col_ff))
      else $error("cursor row/column disagree with cell index");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> slot_free)
      else $error("command taken while result slot busy");

   a_read_follows_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(mem_re))
      else $error("read state without a memory read");

   a_copy_target: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_COPY || state_ff == ST_DRAIN) && mem_we)
         |-> int'(mem_waddr) < LAST_ROW_START)
      else $error("scroll copy writes into last row");
endmodule

[sv/text_console_writer_top.sv]
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   req_type, char_code, attr, at_cursor, col, row
// rsp_chan  out  valid/ready   next_cell, coord_error, read_char, read_attr
// csr_*     in   csr_wr_en     csr_index, csr_wdata (no read-back)
//
// Plain write, backspace, newline, bad-coordinate mark, unused code: one word per
// cycle sustained while rsp_chan.ready is high, no scroll running; a cell read
// holds the back end until its word is issued. Words pass the command queue and
// the result register, a read also the registered store read. Scroll: rows move up
// one, last row zeroed. Clear: all spaces. Reset: all zeroed, req_chan.ready low.
// A 2-word command queue and the result register let input and output stall apart.
module text_console_writer_top #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   tcw_req_if.sink                         req_chan,
   tcw_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata
);
   import tcw_pkg::*;

   logic [7:0]  default_attr_ff;
   logic [7:0]  error_attr_ff;
   logic        init_done;
   logic        q_room;
   logic        q_push;
   logic        q_pop;
   logic        q_valid;
   tcw_cmd_type push_cmd;
   tcw_cmd_type head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= DEFAULT_ATTR_RST;
         error_attr_ff   <= ERROR_ATTR_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEFAULT_ATTR: default_attr_ff <= csr_wdata;
            CSR_ERROR_ATTR:   error_attr_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tcw_front #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_front (
      .req_chan     (req_chan),
      .enable       (init_done),
      .default_attr (default_attr_ff),
      .q_room       (q_room),
      .q_push       (q_push),
      .q_cmd        (push_cmd)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .room       (q_room),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   tcw_back #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (head_cmd),
      .q_pop        (q_pop),
      .default_attr (default_attr_ff),
      .error_attr   (error_attr_ff),
      .init_done    (init_done),
      .rsp_chan     (rsp_chan)
   );
endmodule
